[rtl/lphm_pkg.sv]
// Shared types and constants for the linear probing hash map.
`default_nettype none

package lphm_pkg;

   localparam logic [63:0] FIB_MULT  = 64'd11400714819323198485;
   localparam int          KEY_SHIFT = 4;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;

   typedef struct packed {
      logic        command;
      logic [63:0] key;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [63:0] data_out;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_key_en;
      logic wr_val_en;
   } store_cmd_type;

endpackage

`default_nettype wire

[rtl/lphm_store.sv]
// Slot key and value memories, one access per cycle, registered read data.
`default_nettype none

module lphm_store
   import lphm_pkg::*;
#(
   parameter int IDX_W = 8
) (
   input  wire logic                 clock,
   input  wire store_cmd_type        cmd,
   input  wire logic [IDX_W-1:0]     addr,
   input  wire logic [63:0]          wr_key,
   input  wire logic [63:0]          wr_val,
   output logic      [63:0]          rd_key,
   output logic      [63:0]          rd_val
);

   localparam int DEPTH = 1 << IDX_W;

   logic [63:0] key_mem [DEPTH];
   logic [63:0] val_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (cmd.wr_key_en) begin
         key_mem[addr] <= wr_key;
      end
      if (cmd.rd_en) begin
         rd_key <= key_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_val_en) begin
         val_mem[addr] <= wr_val;
      end
      if (cmd.rd_en) begin
         rd_val <= val_mem[addr];
      end
   end

endmodule

`default_nettype wire

[rtl/linear_probe_hash_map.sv]
// Linear probing hash map: sequencer, hash, probe compare and response register.
//
//   channel | ports                         | beat
//   --------+-------------------------------+------------------------------
//   request | req_valid req_ready req_data  | command, key, value
//   result  | rsp_valid rsp_ready rsp_data  | found, data_out, status
//
// A beat that probes passes a hash step, then one key memory read and compare
// per slot visited, before it reaches the response register. Key zero and
// half-full inserts go straight to the response step without probing.
// After reset the key memory is cleared one slot per cycle, with req_ready low
// throughout. One beat is in flight at a time; a held response only stalls
// the next beat at its final step.
`default_nettype none

module linear_probe_hash_map
   import lphm_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(SLOTS);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W:0]   used_ff, used_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   store_cmd_type    st_cmd;
   logic [63:0]      st_wr_key;
   logic [63:0]      rd_key, rd_val;

   logic [IDX_W-1:0] hash_a, hash_b;
   logic [IDX_W-1:0] hash_prod;
   logic             hit, empty, last;

   lphm_store #(.IDX_W(IDX_W)) u_store (
      .clock  (clock),
      .cmd    (st_cmd),
      .addr   (idx_ff),
      .wr_key (st_wr_key),
      .wr_val (req_ff.value),
      .rd_key (rd_key),
      .rd_val (rd_val)
   );

   // only the low index bits of the product are needed
   assign hash_a    = req_ff.key[KEY_SHIFT +: IDX_W];
   assign hash_b    = FIB_MULT[IDX_W-1:0];
   assign hash_prod = hash_a * hash_b;

   assign hit   = (rd_key == req_ff.key);
   assign empty = (rd_key == 64'd0);
   assign last  = (cnt_ff == {IDX_W{1'b1}});

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign st_wr_key = (state_ff == S_CLEAR) ? 64'd0 : req_ff.key;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      used_in      = used_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      st_cmd       = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            st_cmd.wr_key_en = 1'b1;
            idx_in           = idx_ff + 1'b1;
            if (idx_ff == {IDX_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               cnt_in = '0;
               res_in = '{found: 1'b0, data_out: 64'd0, status: STATUS_OK};
               if (req_data.key == 64'd0) begin
                  if (req_data.command == CMD_INSERT) begin
                     res_in.status = STATUS_ZERO;
                  end
                  state_in = S_RESP;
               end else if (req_data.command == CMD_INSERT &&
                            used_ff >= (IDX_W+1)'(SLOTS / 2)) begin
                  res_in.status = STATUS_FULL;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            idx_in   = hash_prod;
            state_in = S_READ;
         end
         S_READ: begin
            st_cmd.rd_en = 1'b1;
            state_in     = S_CMP;
         end
         S_CMP: begin
            if (hit || empty) begin
               res_in.found    = hit;
               res_in.data_out = hit ? rd_val : 64'd0;
               if (req_ff.command == CMD_INSERT) begin
                  st_cmd.wr_val_en = 1'b1;
                  if (!hit) begin
                     st_cmd.wr_key_en = 1'b1;
                     used_in          = used_ff + 1'b1;
                  end
               end
               state_in = S_RESP;
            end else if (last) begin
               if (req_ff.command == CMD_INSERT) begin
                  res_in.status = STATUS_FULL;
               end
               state_in = S_RESP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= (IDX_W+1)'(SLOTS / 2))
      else $error("used count above half the slots");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (used_in != used_ff) |-> (used_in == used_ff + 1'b1))
      else $error("used count moved by more than one");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after an accepted beat");

   a_claim_empty: assert property (@(posedge clock) disable iff (reset)
      (st_cmd.wr_key_en && state_ff != S_CLEAR) |-> (state_ff == S_CMP && empty))
      else $error("key written over an occupied slot");

endmodule

`default_nettype wire

[dv/tb_linear_probe_hash_map.sv]
// Self-checking testbench for linear_probe_hash_map against a table model.
`default_nettype none

module tb_linear_probe_hash_map;
   import lphm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 256;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int POOL_SIZE = 160;

   typedef struct {
      req_type beat;
      bit      drain_first;
   } stim_beat_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   stim_beat_type pending_beats[$];
   rsp_type     expected_replies[$];
   logic [63:0] table_keys[SLOTS];
   logic [63:0] table_vals[SLOTS];
   int unsigned table_used = 0;
   logic [63:0] key_pool[POOL_SIZE];

   int          mismatch_count = 0;
   int          replies_checked = 0;
   int          gap_left = 0;
   int          burst_left = 1;
   int          holdoff_left = 0;
   bit          holdoff_done = 1'b0;
   int unsigned ready_cycle = 0;
   int unsigned ready_mode = 0;
   logic [31:0] stall_pattern = '1;

   linear_probe_hash_map #(.SLOTS(SLOTS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int unsigned fib_home(logic [63:0] key);
      logic [63:0] product;
      product = (key >> KEY_SHIFT) * FIB_MULT;
      return 32'(product % SLOTS);
   endfunction

   // Applies one beat to the model table and returns the reply it must produce.
   function automatic rsp_type apply_to_table(req_type beat);
      rsp_type     reply;
      int unsigned idx;
      int unsigned n;
      bit          stop;
      reply = '0;
      reply.status = STATUS_OK;
      if (beat.command == CMD_INSERT && beat.key == '0) begin
         reply.status = STATUS_ZERO;
      end else if (beat.command == CMD_INSERT && table_used * 2 >= SLOTS) begin
         reply.status = STATUS_FULL;
      end else if (beat.key != '0) begin
         idx = fib_home(beat.key);
         stop = 1'b0;
         for (n = 0; n < SLOTS && !stop; n++) begin
            if (table_keys[idx] == beat.key || table_keys[idx] == '0)
               stop = 1'b1;
            else
               idx = (idx + 1) % SLOTS;
         end
         if (!stop) begin
            if (beat.command == CMD_INSERT)
               reply.status = STATUS_FULL;
         end else if (table_keys[idx] == beat.key) begin
            reply.found = 1'b1;
            reply.data_out = table_vals[idx];
            if (beat.command == CMD_INSERT)
               table_vals[idx] = beat.value;
         end else if (beat.command == CMD_INSERT) begin
            table_keys[idx] = beat.key;
            table_vals[idx] = beat.value;
            table_used++;
         end
      end
      return reply;
   endfunction

   task automatic add_beat(logic cmd, logic [63:0] key, logic [63:0] value, bit drain = 1'b0);
      stim_beat_type entry;
      entry.beat.command = cmd;
      entry.beat.key = key;
      entry.beat.value = value;
      entry.drain_first = drain;
      pending_beats.push_back(entry);
   endtask

   task automatic report_mismatch(string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   // driver: bursts of beats with random gaps
   always @(posedge clock) begin
      stim_beat_type entry;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_replies.push_back(apply_to_table(req_data));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() == 0 ||
                         (pending_beats[0].drain_first && expected_replies.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               entry = pending_beats.pop_front();
               req_data <= entry.beat;
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  case ($urandom_range(0, 3))
                     0, 1: gap_left = 0;
                     2: gap_left = $urandom_range(1, 4);
                     default: gap_left = $urandom_range(5, 30);
                  endcase
               end
            end
         end
      end
   end

   // receiver: stall mode and pattern redrawn per window, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else if (!holdoff_done && replies_checked >= 150) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            if (ready_cycle % 64 == 0) begin
               ready_mode = $urandom_range(0, 3);
               stall_pattern = $urandom;
            end
            case (ready_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= stall_pattern[ready_cycle % 32];
            endcase
         end
         ready_cycle++;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected reply beat %h", rsp_data));
         end else begin
            want = expected_replies.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch($sformatf("found %b, want %b", rsp_data.found, want.found));
            if (rsp_data.data_out !== want.data_out)
               report_mismatch($sformatf("data_out %h, want %h",
                                         rsp_data.data_out, want.data_out));
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_data.status, want.status));
         end
         replies_checked++;
      end
   end

   initial begin
      logic [63:0] wrap_a;
      logic [63:0] wrap_b;
      logic [63:0] base;
      logic [63:0] key;
      logic [63:0] value;
      logic        cmd;
      int          i;
      int          j;
      int          pick;

      for (i = 0; i < SLOTS; i++) begin
         table_keys[i] = '0;
         table_vals[i] = '0;
      end

      // clusters of four keys that share a home slot
      for (i = 0; i < POOL_SIZE / 4; i++) begin
         base = rand64() & ~64'hF;
         for (j = 0; j < 4; j++)
            key_pool[i * 4 + j] = base | 64'(j + 1);
      end

      do begin
         wrap_a = rand64() & ~64'hF;
      end while (wrap_a == '0 || fib_home(wrap_a) != SLOTS - 1);
      wrap_b = wrap_a | 64'h7;

      // directed
      add_beat(CMD_LOOKUP, '0, '1);
      add_beat(CMD_INSERT, '0, '1);
      add_beat(CMD_LOOKUP, '1, '0);
      add_beat(CMD_INSERT, '1, '1);
      add_beat(CMD_LOOKUP, '1, '0);
      add_beat(CMD_INSERT, '1, '0);
      add_beat(CMD_LOOKUP, '1, rand64());
      add_beat(CMD_INSERT, 64'd1, rand64());
      add_beat(CMD_INSERT, 64'd15, rand64());
      add_beat(CMD_LOOKUP, 64'd15, '0);
      add_beat(CMD_LOOKUP, 64'd2, '0);
      add_beat(CMD_INSERT, wrap_a, rand64());
      add_beat(CMD_INSERT, wrap_b, rand64());
      add_beat(CMD_LOOKUP, wrap_b, '0);
      add_beat(CMD_LOOKUP, wrap_a, '1);
      add_beat(CMD_INSERT, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 1'b1);
      add_beat(CMD_LOOKUP, 64'h8000_0000_0000_0000, '0);
      add_beat(CMD_LOOKUP, '0, '0);
      add_beat(CMD_INSERT, 64'h10, 64'hAAAA_AAAA_AAAA_AAAA);
      add_beat(CMD_INSERT, wrap_b, '1);
      add_beat(CMD_LOOKUP, wrap_b, '0);

      // random: mostly pool keys, so the table fills to its limit and stays there
      for (i = 0; i < 400; i++) begin
         cmd = ($urandom_range(0, 99) < 55) ? CMD_INSERT : CMD_LOOKUP;
         pick = $urandom_range(0, 99);
         if (pick < 78)
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else if (pick < 88)
            key = rand64();
         else if (pick < 93)
            key = '0;
         else if (pick < 96)
            case ($urandom_range(0, 2))
               0: key = '1;
               1: key = 64'h8000_0000_0000_0000;
               default: key = wrap_b;
            endcase
         else
            key = 64'($urandom_range(1, 15));
         pick = $urandom_range(0, 9);
         value = (pick == 0) ? '0 : (pick == 1) ? '1 : rand64();
         add_beat(cmd, key, value, i == 250);
      end

      while (pending_beats.size() != 0 || req_valid || expected_replies.size() != 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
rtl/lphm_pkg.sv
rtl/lphm_store.sv
rtl/linear_probe_hash_map.sv
dv/tb_linear_probe_hash_map.sv
